// ===== src/icb_pkg.sv =====
// Shared types and constants of the crop and binning unit.
// Depends on nothing; the other files that use it refer to it by scoped names.
package icb_pkg;

    localparam int GW         = 14;
    localparam int COL_BITS   = 13;
    localparam int PIX_W      = 16;
    localparam int DIV_N      = 16;
    localparam int DIV_D      = 9;
    localparam int SUM_W      = 22;
    localparam int CSUM_W     = 19;
    localparam int ACC_W      = 20;
    localparam int BIN_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_FIRST      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_LAST       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_FIRST      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LAST       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_FACTOR   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_MODE     = 3'd7;

    typedef struct packed {
        logic [15:0] pixel_value;
        logic        frame_start;
    } t_pixel_in;

    typedef struct packed {
        logic [21:0] binned_value;
        logic        frame_end;
    } t_bin_out;

    typedef struct packed {
        logic                sliding;
        logic                first;
        logic                emit;
        logic                last;
        logic [BIN_W-1:0]    bin;
        logic [BIN_W-1:0]    slot;
        logic [BIN_W-1:0]    wsel;
        logic [COL_BITS-1:0] col;
        logic [PIX_W-1:0]    sample;
    } t_work;

endpackage

// ===== src/image_crop_and_binning_unit.sv =====
// Top level of the crop and binning unit.
// Depends on icb_pkg, icb_front, icb_back and icb_fifo.
//
// Pixels enter in raster order through a queue-style port: an item transfers
// when push is high and full is low. Each pixel carries frame_start, which
// puts it at row 0, column 0. Binned results leave through a second queue:
// while empty is low the oldest result sits on o_result, and it transfers
// when pop is high. frame_end marks the last bin of the frame.
// Registers are written through the cfg channel (ready is always high),
// index 0..7 in the order frame width, frame height, window x first/last,
// window y first/last, bin factor, bin mode.
// The front end holds full high from each accepted pixel until its 16-step
// dividers (column and window size by the bin factor, row by it or by one
// less, sample by its square in average mode) are done and the item has
// been handed on. A block result then passes a row accumulator read and
// update; a sliding result passes line store reads (b above one) and a
// column sum pass. A two-entry queue sits between front and back and another
// at the output, so a stalled receiver backs up into full without loss.
// Reset (synchronous, active low) restores register defaults and clears
// counters, queues and column sums; the stores need no clearing pass.
module image_crop_and_binning_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_BIN    = 8,
    parameter int PIXEL_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  icb_pkg::t_pixel_in             i_pixel,
    output logic                           empty,
    input  logic                           pop,
    output icb_pkg::t_bin_out              o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [icb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [icb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    logic              work_push, work_full, work_pop, work_empty;
    icb_pkg::t_work    work_in, work_out;
    logic              out_push, out_full;
    icb_pkg::t_bin_out out_data;

    icb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_BIN    (MAX_BIN),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_pixel     (i_pixel),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_work_push (work_push),
        .o_work      (work_in),
        .i_work_full (work_full)
    );

    icb_fifo #(.T(icb_pkg::t_work), .DEPTH(2)) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (work_push),
        .i_data  (work_in),
        .o_full  (work_full),
        .i_pop   (work_pop),
        .o_data  (work_out),
        .o_empty (work_empty)
    );

    icb_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BIN   (MAX_BIN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_empty (work_empty),
        .i_work       (work_out),
        .o_work_pop   (work_pop),
        .i_out_full   (out_full),
        .o_out_push   (out_push),
        .o_out        (out_data)
    );

    icb_fifo #(.T(icb_pkg::t_bin_out), .DEPTH(2)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_data),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );
endmodule

// ===== src/icb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module icb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/icb_fifo.sv =====
// Small synchronous queue of any packed type, flop storage.
// Depends on nothing.
module icb_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    T              r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end
endmodule

// ===== src/icb_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on icb_pkg for operand widths.
module icb_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [icb_pkg::DIV_N-1:0] i_dividend,
    input  logic [icb_pkg::DIV_D-1:0] i_divisor,
    output logic                    o_done,
    output logic [icb_pkg::DIV_N-1:0] o_quotient,
    output logic [icb_pkg::DIV_D-1:0] o_remainder
);
    localparam int N  = icb_pkg::DIV_N;
    localparam int D  = icb_pkg::DIV_D;
    localparam int CW = $clog2(N);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [D-1:0]  r_div;
    logic [D:0]    trial;
    logic          ge;

    assign trial = {o_remainder, o_quotient[N-1]};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            o_quotient  <= i_dividend;
            o_remainder <= '0;
            r_div       <= i_divisor;
        end else if (r_busy) begin
            o_remainder <= ge ? D'(trial - {1'b0, r_div}) : D'(trial);
            o_quotient  <= {o_quotient[N-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(N - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== src/icb_front.sv =====
// Front end: configuration registers, position counters, window test and
// tile/phase classification. Depends on icb_pkg and icb_div.
module icb_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_BIN    = 8,
    parameter int PIXEL_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  icb_pkg::t_pixel_in                 i_pixel,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [icb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [icb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_work_push,
    output icb_pkg::t_work                     o_work,
    input  logic                               i_work_full
);
    localparam int GW = icb_pkg::GW;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int BW = icb_pkg::BIN_W;
    localparam int N  = icb_pkg::DIV_N;
    localparam int D  = icb_pkg::DIV_D;
    localparam logic [N-1:0] PIX_MASK = N'((32'd1 << PIXEL_BITS) - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [10:0]   r_fw, r_fh;
    logic [9:0]    r_x0, r_x1, r_y0, r_y1;
    logic [BW-1:0] r_binreg;
    logic [1:0]    r_mode;

    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;
    logic [1:0]    r_state;

    logic          r_inwin, r_sliding;
    logic [BW-1:0] r_bin;
    logic [XW-1:0] r_cx;
    logic [YW-1:0] r_cy;
    logic [XW:0]   r_ww;
    logic [YW:0]   r_hh;

    logic [GW-1:0] fw_e, fh_e, fw_g, fh_g;
    logic [GW-1:0] xa, xb, ya, yb, xlo, xhi, ylo, yhi;
    logic [GW-1:0] cur_col, cur_row, col_inc, row_inc, cx_g, cy_g, ww_g, hh_g;
    logic [BW-1:0] b_c;
    logic          accept, inwin, sliding, average;

    logic [4:0]         start;
    logic [4:0]         done;
    logic [N-1:0]       q [5];
    logic [D-1:0]       rm [5];
    logic [N-1:0]       dvd [5];
    logic [D-1:0]       dvs [5];

    logic          keep;
    logic          blk_keep, blk_first, blk_emit, blk_last;
    logic          sl_emit, sl_last;
    logic [D-1:0]  bm1;

    assign o_cfg_ready = 1'b1;
    assign o_full      = (r_state != S_IDLE);
    assign accept      = i_push && !o_full;
    assign sliding     = r_mode[1];
    assign average     = r_mode[0];

    always_comb begin
        fw_e = GW'(r_fw);
        fh_e = GW'(r_fh);
        fw_g = (fw_e == '0) ? GW'(1) : ((fw_e > GW'(MAX_WIDTH)) ? GW'(MAX_WIDTH) : fw_e);
        fh_g = (fh_e == '0) ? GW'(1) : ((fh_e > GW'(MAX_HEIGHT)) ? GW'(MAX_HEIGHT) : fh_e);
        if (r_binreg == '0) begin
            b_c = BW'(1);
        end else if (5'(r_binreg) > 5'(MAX_BIN)) begin
            b_c = BW'(MAX_BIN);
        end else begin
            b_c = r_binreg;
        end
        xa  = (GW'(r_x0) > fw_g - 1'b1) ? fw_g - 1'b1 : GW'(r_x0);
        xb  = (GW'(r_x1) > fw_g - 1'b1) ? fw_g - 1'b1 : GW'(r_x1);
        ya  = (GW'(r_y0) > fh_g - 1'b1) ? fh_g - 1'b1 : GW'(r_y0);
        yb  = (GW'(r_y1) > fh_g - 1'b1) ? fh_g - 1'b1 : GW'(r_y1);
        xlo = (xa > xb) ? xb : xa;
        xhi = (xa > xb) ? xa : xb;
        ylo = (ya > yb) ? yb : ya;
        yhi = (ya > yb) ? ya : yb;
        ww_g = xhi - xlo + 1'b1;
        hh_g = yhi - ylo + 1'b1;
        cur_col = i_pixel.frame_start ? '0 : GW'(r_col);
        cur_row = i_pixel.frame_start ? '0 : GW'(r_row);
        inwin = (cur_col >= xlo) && (cur_col <= xhi) && (cur_row >= ylo) && (cur_row <= yhi);
        cx_g = cur_col - xlo;
        cy_g = cur_row - ylo;
        col_inc = cur_col + 1'b1;
        row_inc = cur_row + 1'b1;
    end

    always_comb begin
        start  = {5{accept}};
        dvd[0] = N'(cx_g);
        dvs[0] = D'(b_c);
        dvd[1] = N'(cy_g);
        dvs[1] = (sliding && b_c != BW'(1)) ? D'(b_c - 1'b1) : D'(b_c);
        dvd[2] = i_pixel.pixel_value & PIX_MASK;
        dvs[2] = average ? D'(b_c * b_c) : D'(1);
        dvd[3] = N'(ww_g);
        dvs[3] = D'(b_c);
        dvd[4] = N'(hh_g);
        dvs[4] = D'(b_c);
    end

    for (genvar g = 0; g < 5; g++) begin : g_div
        icb_div u_div (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_start     (start[g]),
            .i_dividend  (dvd[g]),
            .i_divisor   (dvs[g]),
            .o_done      (done[g]),
            .o_quotient  (q[g]),
            .o_remainder (rm[g])
        );
    end

    always_comb begin
        bm1       = D'(r_bin) - 1'b1;
        blk_keep  = (q[0] < q[3]) && (q[1] < q[4]);
        blk_first = (rm[0] == '0) && (rm[1] == '0);
        blk_emit  = (rm[0] == bm1) && (rm[1] == bm1);
        blk_last  = (q[0] == q[3] - 1'b1) && (q[1] == q[4] - 1'b1);
        sl_emit   = (GW'(r_cx) >= GW'(bm1)) && (GW'(r_cy) >= GW'(bm1));
        sl_last   = (GW'(r_cx) == GW'(r_ww) - 1'b1) && (GW'(r_cy) == GW'(r_hh) - 1'b1);
        keep      = r_inwin && (r_sliding || blk_keep);

        o_work.sliding = r_sliding;
        o_work.first   = blk_first;
        o_work.emit    = r_sliding ? sl_emit : blk_emit;
        o_work.last    = r_sliding ? sl_last : (blk_emit && blk_last);
        o_work.bin     = r_bin;
        o_work.slot    = BW'(rm[1]);
        o_work.wsel    = BW'(rm[0]);
        o_work.col     = r_sliding ? icb_pkg::COL_BITS'(r_cx) : icb_pkg::COL_BITS'(q[0]);
        o_work.sample  = q[2];
        o_work_push    = (r_state == S_PUSH) && keep && !i_work_full;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_inwin   <= inwin;
            r_sliding <= sliding;
            r_bin     <= b_c;
            r_cx      <= XW'(cx_g);
            r_cy      <= YW'(cy_g);
            r_ww      <= (XW+1)'(ww_g);
            r_hh      <= (YW+1)'(hh_g);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw     <= 11'd1024;
            r_fh     <= 11'd1024;
            r_x0     <= 10'd0;
            r_x1     <= 10'd1023;
            r_y0     <= 10'd0;
            r_y1     <= 10'd1023;
            r_binreg <= BW'(1);
            r_mode   <= 2'd0;
            r_col    <= '0;
            r_row    <= '0;
            r_state  <= S_IDLE;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    icb_pkg::CFG_FRAME_WIDTH:  r_fw     <= i_cfg_data;
                    icb_pkg::CFG_FRAME_HEIGHT: r_fh     <= i_cfg_data;
                    icb_pkg::CFG_X_FIRST:      r_x0     <= i_cfg_data[9:0];
                    icb_pkg::CFG_X_LAST:       r_x1     <= i_cfg_data[9:0];
                    icb_pkg::CFG_Y_FIRST:      r_y0     <= i_cfg_data[9:0];
                    icb_pkg::CFG_Y_LAST:       r_y1     <= i_cfg_data[9:0];
                    icb_pkg::CFG_BIN_FACTOR:   r_binreg <= i_cfg_data[BW-1:0];
                    icb_pkg::CFG_BIN_MODE:     r_mode   <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (col_inc >= fw_g) begin
                    r_col <= '0;
                    r_row <= (row_inc >= fh_g) ? '0 : YW'(row_inc);
                end else begin
                    r_col <= XW'(col_inc);
                    r_row <= YW'(cur_row);
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (&done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!keep || !i_work_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/icb_back.sv =====
// Back end: tile accumulation, line store and sliding column sums.
// Depends on icb_pkg and icb_ram.
module icb_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_BIN   = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_work_empty,
    input  icb_pkg::t_work   i_work,
    output logic             o_work_pop,
    input  logic             i_out_full,
    output logic             o_out_push,
    output icb_pkg::t_bin_out o_out
);
    localparam int RAW      = $clog2(MAX_WIDTH);
    localparam int LS_DEPTH = ((MAX_BIN > 1) ? MAX_BIN - 1 : 1) * MAX_WIDTH;
    localparam int LAW      = $clog2(LS_DEPTH);
    localparam int WB       = (MAX_BIN > 1) ? $clog2(MAX_BIN) : 1;
    localparam int BW       = icb_pkg::BIN_W;
    localparam int SW       = icb_pkg::SUM_W;
    localparam int AW       = icb_pkg::ACC_W;
    localparam int CSW      = icb_pkg::CSUM_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_BLK_RD  = 3'd1;
    localparam logic [2:0] S_BLK_ADD = 3'd2;
    localparam logic [2:0] S_LS_RD   = 3'd3;
    localparam logic [2:0] S_LS_LAST = 3'd4;
    localparam logic [2:0] S_WCS     = 3'd5;
    localparam logic [2:0] S_SUM     = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    logic [2:0]      r_state;
    icb_pkg::t_work  r_item;
    logic [AW-1:0]   r_colsum;
    logic [SW-1:0]   r_total;
    logic [BW-1:0]   r_slot;
    logic [BW-1:0]   r_cnt;
    logic [CSW-1:0]  r_wcs [MAX_BIN];

    logic            ra_we;
    logic [SW-1:0]   ra_rdata, ra_wdata;
    logic            ls_we;
    logic [LAW-1:0]  ls_raddr, ls_waddr;
    logic [15:0]     ls_rdata;
    logic [BW-1:0]   dep;

    assign dep        = r_item.bin - 1'b1;
    assign o_work_pop = (r_state == S_IDLE) && !i_work_empty;
    assign o_out_push = (r_state == S_OUT) && !i_out_full;
    assign o_out.binned_value = r_total;
    assign o_out.frame_end    = r_item.last;

    assign ra_we    = (r_state == S_BLK_ADD);
    assign ra_wdata = r_item.first ? SW'(r_item.sample)
                                   : SW'(ra_rdata + SW'(r_item.sample));
    assign ls_we    = (r_state == S_LS_LAST);
    assign ls_raddr = LAW'(32'(r_slot) * 32'(MAX_WIDTH) + 32'(r_item.col));
    assign ls_waddr = LAW'(32'(r_item.slot) * 32'(MAX_WIDTH) + 32'(r_item.col));

    icb_ram #(.WIDTH(SW), .DEPTH(MAX_WIDTH)) u_row_acc (
        .i_clk   (i_clk),
        .i_we    (ra_we),
        .i_waddr (r_item.col[RAW-1:0]),
        .i_wdata (ra_wdata),
        .i_raddr (r_item.col[RAW-1:0]),
        .o_rdata (ra_rdata)
    );

    icb_ram #(.WIDTH(16), .DEPTH(LS_DEPTH)) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ls_we),
        .i_waddr (ls_waddr),
        .i_wdata (r_item.sample),
        .i_raddr (ls_raddr),
        .o_rdata (ls_rdata)
    );

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_item   <= i_work;
                r_colsum <= AW'(i_work.sample);
                r_slot   <= (i_work.slot == '0) ? i_work.bin - 2'd2 : i_work.slot - 1'b1;
                r_cnt    <= BW'(1);
            end
            S_BLK_ADD: begin
                r_total <= ra_wdata;
            end
            S_LS_RD: begin
                if (r_cnt != BW'(1)) begin
                    r_colsum <= r_colsum + AW'(ls_rdata);
                end
                r_slot <= (r_slot == '0) ? dep - 1'b1 : r_slot - 1'b1;
                r_cnt  <= r_cnt + 1'b1;
            end
            S_LS_LAST: begin
                r_colsum <= r_colsum + AW'(ls_rdata);
            end
            S_WCS: begin
                r_cnt   <= '0;
                r_total <= '0;
            end
            S_SUM: begin
                r_total <= SW'(r_total + SW'(r_wcs[r_cnt[WB-1:0]]));
                r_cnt   <= r_cnt + 1'b1;
            end
            S_BLK_RD, S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int i = 0; i < MAX_BIN; i++) begin
                r_wcs[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_work_empty) begin
                        if (!i_work.sliding) begin
                            r_state <= S_BLK_RD;
                        end else if (i_work.bin > BW'(1)) begin
                            r_state <= S_LS_RD;
                        end else begin
                            r_state <= S_WCS;
                        end
                    end
                end
                S_BLK_RD: r_state <= S_BLK_ADD;
                S_BLK_ADD: r_state <= r_item.emit ? S_OUT : S_IDLE;
                S_LS_RD: begin
                    if (r_cnt == dep) begin
                        r_state <= S_LS_LAST;
                    end
                end
                S_LS_LAST: r_state <= S_WCS;
                S_WCS: begin
                    r_wcs[r_item.wsel[WB-1:0]] <= CSW'(r_colsum);
                    r_state <= r_item.emit ? S_SUM : S_IDLE;
                end
                S_SUM: begin
                    if (r_cnt == dep) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> !i_out_full)
        else $error("result pushed into full queue");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_work_pop |=> (r_state != S_IDLE))
        else $error("work popped without starting");
    a_blk_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLK_RD) |=> (r_state == S_BLK_ADD) && $past(!r_item.sliding))
        else $error("block read not followed by update");
    a_ls_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ls_we |-> r_item.sliding && (r_item.bin > BW'(1)))
        else $error("line store written outside sliding mode");
endmodule

// ===== test/tb_image_crop_and_binning_unit.sv =====
// Testbench for image_crop_and_binning_unit: directed table, then random frames
// under random register settings; results checked vs a local predictor or table.
// Depends on icb_pkg and the unit under test.
`timescale 1ns / 1ps

module tb_image_crop_and_binning_unit;

    typedef struct {
        bit                                 is_cfg;
        logic [icb_pkg::CFG_IDX_W-1:0]      idx;
        logic [icb_pkg::CFG_DATA_W-1:0]     data;
        logic [15:0]                        pixel;
        bit                                 fs;
        bit                                 typed;
        logic [21:0]                        bin_val;
        bit                                 bin_end;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           push;
    logic                           full;
    icb_pkg::t_pixel_in             i_pixel;
    logic                           empty;
    logic                           pop;
    icb_pkg::t_bin_out              o_result;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [icb_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [icb_pkg::CFG_DATA_W-1:0] i_cfg_data;

    logic [10:0] reg_fw, reg_fh;
    logic [9:0]  reg_x0, reg_x1, reg_y0, reg_y1;
    logic [3:0]  reg_bin;
    logic [1:0]  reg_mode;
    int unsigned col_cnt, row_cnt;
    logic [21:0] tile_acc [0:1023];
    logic [15:0] line_mem [0:8191];
    logic [18:0] col_sums [0:7];

    icb_pkg::t_bin_out expected_bins [$];
    int          errors;
    int          pixels_sent;
    int          bins_seen;
    int          phases;
    int          cycle_cnt;
    int          idle_pct;
    t_row        table_rows [$];

    image_crop_and_binning_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_pixel     (i_pixel),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        idle_pct  <= (cycle_cnt > 4000 && cycle_cnt < 9000) ? 0 : 22;
        pop       <= i_rst_n && ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            bins_seen++;
            if (expected_bins.size() == 0) begin
                errors++;
                $display("%0t: unexpected result value=%0d end=%0b", $time,
                         o_result.binned_value, o_result.frame_end);
            end else begin
                icb_pkg::t_bin_out want;
                want = expected_bins.pop_front();
                if (o_result.binned_value !== want.binned_value) begin
                    errors++;
                    $display("%0t: binned_value expected %0d actual %0d", $time,
                             want.binned_value, o_result.binned_value);
                end
                if (o_result.frame_end !== want.frame_end) begin
                    errors++;
                    $display("%0t: frame_end expected %0b actual %0b", $time,
                             want.frame_end, o_result.frame_end);
                end
            end
        end
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned max_v);
        if (v < 1) return 1;
        return (v > max_v) ? max_v : v;
    endfunction

    function automatic int unsigned clamp_idx(int unsigned v, int unsigned size);
        return (v > size - 1) ? size - 1 : v;
    endfunction

    function automatic bit bin_predict(input icb_pkg::t_pixel_in px,
                                       output icb_pkg::t_bin_out r);
        int unsigned fw, fh, b, xa, xb, ya, yb, t, col, row, smp, ww, hh, cx, cy;
        int unsigned wlim, hlim, tc, depth, slot, k, total, colsum;
        logic [21:0] acc;
        bit slide, avg, hit;
        fw    = clamp_size(reg_fw, 1024);
        fh    = clamp_size(reg_fh, 1024);
        b     = clamp_size(reg_bin, 8);
        xa    = clamp_idx(reg_x0, fw);
        xb    = clamp_idx(reg_x1, fw);
        ya    = clamp_idx(reg_y0, fh);
        yb    = clamp_idx(reg_y1, fh);
        slide = reg_mode[1];
        avg   = reg_mode[0];
        hit   = 1'b0;
        r     = '0;
        if (xa > xb) begin
            t = xa; xa = xb; xb = t;
        end
        if (ya > yb) begin
            t = ya; ya = yb; yb = t;
        end
        ww = xb - xa + 1;
        hh = yb - ya + 1;
        if (px.frame_start) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        col = col_cnt;
        row = row_cnt;
        smp = avg ? px.pixel_value / (b * b) : px.pixel_value;
        if (col >= xa && col <= xb && row >= ya && row <= yb) begin
            cx = col - xa;
            cy = row - ya;
            if (!slide) begin
                wlim = (ww / b) * b;
                hlim = (hh / b) * b;
                if (cx < wlim && cy < hlim) begin
                    tc = cx / b;
                    if (cx % b == 0 && cy % b == 0) acc = 22'(smp);
                    else acc = 22'(tile_acc[tc] + smp);
                    tile_acc[tc] = acc;
                    if (cx % b == b - 1 && cy % b == b - 1) begin
                        r.binned_value = acc;
                        r.frame_end    = (cx == wlim - 1 && cy == hlim - 1);
                        hit = 1'b1;
                    end
                end
            end else begin
                colsum = smp;
                if (b > 1) begin
                    depth = b - 1;
                    for (k = 1; k < b; k++) begin
                        slot = ((cy + depth * 8) - k) % depth;
                        colsum += line_mem[slot * 1024 + cx];
                    end
                    line_mem[(cy % depth) * 1024 + cx] = 16'(smp);
                end
                col_sums[cx % b] = colsum[18:0];
                if (cx >= b - 1 && cy >= b - 1) begin
                    total = 0;
                    for (k = 0; k < b; k++) total += col_sums[k];
                    r.binned_value = total[21:0];
                    r.frame_end    = (cx == ww - 1 && cy == hh - 1);
                    hit = 1'b1;
                end
            end
        end
        col++;
        if (col >= fw) begin
            col = 0;
            row++;
            if (row >= fh) row = 0;
        end
        col_cnt = col;
        row_cnt = row;
        return hit;
    endfunction

    task automatic hold_idle(int pct);
        while ($urandom_range(0, 99) < pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // leaves push high after the transfer
    task automatic send_pixel(logic [15:0] pix, bit fs, bit typed,
                              icb_pkg::t_bin_out typed_bin);
        icb_pkg::t_pixel_in px;
        icb_pkg::t_bin_out  bin;
        hold_idle(idle_pct);
        px.pixel_value = pix;
        px.frame_start = fs;
        push    <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (full);
        pixels_sent++;
        if (bin_predict(px, bin)) expected_bins.push_back(typed ? typed_bin : bin);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // leaves valid high after the transfer
    task automatic write_reg(logic [icb_pkg::CFG_IDX_W-1:0]  idx,
                             logic [icb_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            icb_pkg::CFG_FRAME_WIDTH:  reg_fw   = data;
            icb_pkg::CFG_FRAME_HEIGHT: reg_fh   = data;
            icb_pkg::CFG_X_FIRST:      reg_x0   = data[9:0];
            icb_pkg::CFG_X_LAST:       reg_x1   = data[9:0];
            icb_pkg::CFG_Y_FIRST:      reg_y0   = data[9:0];
            icb_pkg::CFG_Y_LAST:       reg_y1   = data[9:0];
            icb_pkg::CFG_BIN_FACTOR:   reg_bin  = data[3:0];
            default:                   reg_mode = data[1:0];
        endcase
    endtask

    function automatic t_row pix_row(logic [15:0] p, bit fs, bit typed);
        t_row r;
        r = '{default: '0};
        r.pixel   = p;
        r.fs      = fs;
        r.typed   = typed;
        r.bin_val = 22'(p);
        return r;
    endfunction

    function automatic t_row cfg_row(logic [icb_pkg::CFG_IDX_W-1:0]  idx,
                                     logic [icb_pkg::CFG_DATA_W-1:0] d);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = d;
        return r;
    endfunction

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] rand_corner();
        return ($urandom_range(0, 11) == 0) ? 10'd1023 : 10'($urandom_range(0, 15));
    endfunction

    initial begin
        icb_pkg::t_bin_out tb;
        int fw_raw, fh_raw, fwe, fhe, frame_len, len, n_frames;
        bit big_w_done, big_h_done, in_cfg, fs;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_pixel     = '0;
        pop         = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = icb_pkg::CFG_FRAME_WIDTH;
        i_cfg_data  = '0;
        errors      = 0;
        pixels_sent = 0;
        bins_seen   = 0;
        phases      = 0;
        cycle_cnt   = 0;
        idle_pct    = 22;
        big_w_done  = 1'b0;
        big_h_done  = 1'b0;
        reg_fw = 11'd1024; reg_fh = 11'd1024;
        reg_x0 = 10'd0;    reg_x1 = 10'd1023;
        reg_y0 = 10'd0;    reg_y1 = 10'd1023;
        reg_bin = 4'd1;    reg_mode = 2'd0;
        col_cnt = 0;
        row_cnt = 0;
        foreach (col_sums[i]) col_sums[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: full frame window, bin 1, block sum passes pixels through
        table_rows.push_back(pix_row(16'h0000, 1'b1, 1'b1));
        table_rows.push_back(pix_row(16'hFFFF, 1'b0, 1'b1));
        table_rows.push_back(pix_row(16'h0001, 1'b0, 1'b1));
        table_rows.push_back(pix_row(16'h8000, 1'b0, 1'b1));
        table_rows.push_back(pix_row(16'h5555, 1'b0, 1'b1));
        table_rows.push_back(pix_row(16'hAAAA, 1'b0, 1'b1));
        table_rows.push_back(pix_row(16'h7FFF, 1'b0, 1'b1));
        // shrink width under a counter past the frame edge, zero height, sliding sum
        table_rows.push_back(cfg_row(icb_pkg::CFG_FRAME_WIDTH, 11'd4));
        table_rows.push_back(cfg_row(icb_pkg::CFG_FRAME_HEIGHT, 11'd0));
        table_rows.push_back(cfg_row(icb_pkg::CFG_BIN_MODE, 11'd2));
        table_rows.push_back(pix_row(16'h1234, 1'b0, 1'b0));
        table_rows.push_back(pix_row(16'hFFFF, 1'b0, 1'b0));
        table_rows.push_back(pix_row(16'h0002, 1'b0, 1'b0));
        // reversed and clamped window, oversized bin, sliding average, then bin 2
        table_rows.push_back(cfg_row(icb_pkg::CFG_FRAME_HEIGHT, 11'd3));
        table_rows.push_back(cfg_row(icb_pkg::CFG_X_FIRST, 11'd1023));
        table_rows.push_back(cfg_row(icb_pkg::CFG_X_LAST, 11'd1));
        table_rows.push_back(cfg_row(icb_pkg::CFG_Y_FIRST, 11'd2));
        table_rows.push_back(cfg_row(icb_pkg::CFG_Y_LAST, 11'd0));
        table_rows.push_back(cfg_row(icb_pkg::CFG_BIN_FACTOR, 11'd15));
        table_rows.push_back(cfg_row(icb_pkg::CFG_BIN_MODE, 11'd3));
        for (int i = 0; i < 12; i++) table_rows.push_back(pix_row(16'hFFFF, i == 0, 1'b0));
        table_rows.push_back(cfg_row(icb_pkg::CFG_BIN_FACTOR, 11'd2));
        for (int i = 0; i < 12; i++) begin
            table_rows.push_back(pix_row(16'(32'hFFF0 + i), i == 0, 1'b0));
        end

        in_cfg = 1'b0;
        foreach (table_rows[i]) begin
            if (table_rows[i].is_cfg) begin
                if (!in_cfg) drain();
                in_cfg = 1'b1;
                write_reg(table_rows[i].idx, table_rows[i].data);
            end else begin
                if (in_cfg) i_cfg_valid <= 1'b0;
                in_cfg = 1'b0;
                tb.binned_value = table_rows[i].bin_val;
                tb.frame_end    = 1'b0;
                send_pixel(table_rows[i].pixel, table_rows[i].fs, table_rows[i].typed, tb);
            end
        end

        while (pixels_sent < 560) begin
            drain();
            phases++;
            fw_raw = $urandom_range(1, 12);
            fh_raw = $urandom_range(1, 12);
            case ($urandom_range(0, 15))
                0: fw_raw = 0;
                1: fh_raw = 0;
                2: if (!big_w_done) begin
                    fw_raw = 2047; fh_raw = 1; big_w_done = 1'b1;
                end
                3: if (!big_h_done) begin
                    fh_raw = 2047; big_h_done = 1'b1;
                end
                default: ;
            endcase
            write_reg(icb_pkg::CFG_FRAME_WIDTH, 11'(fw_raw));
            write_reg(icb_pkg::CFG_FRAME_HEIGHT, 11'(fh_raw));
            write_reg(icb_pkg::CFG_X_FIRST, 11'(rand_corner()));
            write_reg(icb_pkg::CFG_X_LAST, 11'(rand_corner()));
            write_reg(icb_pkg::CFG_Y_FIRST, 11'(rand_corner()));
            write_reg(icb_pkg::CFG_Y_LAST, 11'(rand_corner()));
            write_reg(icb_pkg::CFG_BIN_FACTOR,
                      11'(($urandom_range(0, 11) == 0) ? 15 : $urandom_range(0, 4)));
            write_reg(icb_pkg::CFG_BIN_MODE, 11'($urandom_range(0, 3)));
            i_cfg_valid <= 1'b0;
            fwe = clamp_size(fw_raw, 1024);
            fhe = clamp_size(fh_raw, 1024);
            frame_len = fwe * fhe;
            if (frame_len > 150) frame_len = 150;
            n_frames = $urandom_range(1, 3);
            tb = '0;
            for (int f = 0; f < n_frames; f++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, frame_len) : frame_len;
                for (int p = 0; p < len; p++) begin
                    fs = (p == 0) && !(col_cnt == 0 && row_cnt == 0 && $urandom_range(0, 3) == 0);
                    if ($urandom_range(0, 199) == 0) fs = 1'b1;
                    send_pixel(rand_pixel(), fs, 1'b0, tb);
                end
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (expected_bins.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, expected_bins.size());
        end
        $display("Covered %0d pixels and %0d binned results over %0d random settings,",
                 pixels_sent, bins_seen, phases);
        $display("all four binning modes, clamped and reversed windows, %0d mismatches.",
                 errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/icb_pkg.sv
src/icb_ram.sv
src/icb_fifo.sv
src/icb_div.sv
src/icb_front.sv
src/icb_back.sv
src/image_crop_and_binning_unit.sv
test/tb_image_crop_and_binning_unit.sv
